/* hw/rtl/lcs_pkg.sv */
// Package for the looping command sequencer: item types, codes, sizes.
// No dependencies.
package lcs_pkg;

  localparam int MaxSteps   = 64;
  localparam int MaxNest    = 4;
  localparam int IdxW       = $clog2(MaxSteps);
  localparam int NestW      = $clog2(MaxNest);
  localparam int StepW      = 57;
  localparam logic [31:0] DefaultBudget = 32'd100000;
  localparam logic [13:0] RepeatMax     = 14'd16383;

  typedef enum logic [3:0] {
    OP_LOG = 4'd0, OP_CHAN = 4'd1, OP_SWEEP = 4'd2, OP_SCAN = 4'd3,
    OP_TX = 4'd4, OP_WAIT = 4'd5, OP_REPEAT = 4'd6, OP_END = 4'd7
  } op_t;

  localparam logic [1:0] ModeLoad  = 2'd0;
  localparam logic [1:0] ModeStart = 2'd1;
  localparam logic [1:0] ModeNext  = 2'd2;

  localparam logic [2:0] KChan = 3'd0;
  localparam logic [2:0] KScan = 3'd1;
  localparam logic [2:0] KTx   = 3'd2;
  localparam logic [2:0] KWait = 3'd3;
  localparam logic [2:0] KLog  = 3'd4;
  localparam logic [2:0] KDone = 3'd5;

  localparam logic [2:0] SOk     = 3'd0;
  localparam logic [2:0] SOpcode = 3'd1;
  localparam logic [2:0] SUnbal  = 3'd2;
  localparam logic [2:0] SNest   = 3'd3;
  localparam logic [2:0] SDenied = 3'd4;
  localparam logic [2:0] SAbort  = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE, ST_FETCH, ST_EXEC, ST_GRANT, ST_SWEEP
  } state_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [5:0]  step_index;
    logic [3:0]  step_op;
    logic [19:0] arg_a;
    logic [16:0] arg_b;
    logic [15:0] arg_c;
    logic [6:0]  step_total;
    logic [31:0] run_budget;
    logic        abort_now;
    logic        tx_granted;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  cmd_kind;
    logic [19:0] cmd_value;
    logic [3:0]  tx_setting;
    logic [2:0]  run_status;
    logic [5:0]  failed_at;
    logic [31:0] executed_count;
    logic [31:0] frames_asked;
    logic [31:0] frames_allowed;
  } out_item_t;

endpackage

/* hw/rtl/looping_command_sequencer_unit.sv */
// Looping command sequencer top level.
// A next item visits steps, each fetched from program RAM, then executed, and
// registers the result strobe. A run may end at the fetch; a sweep pair's second
// command comes from the sweep state; a grant answer passes the grant state first.
// Load and start give no result. One item at a time; busy drops in the result cycle,
// the receiver cannot stall. Sync reset clears control; program memory stays undefined.
module looping_command_sequencer_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  lcs_pkg::in_item_t    in_item,
  output logic                 result_valid,
  output lcs_pkg::out_item_t   result
);
  import lcs_pkg::*;

  state_t state, state_next;

  logic [IdxW:0]  pc, pc_next, plen;
  logic [31:0]    budget, budget_next;
  logic [NestW:0] depth, depth_next;
  logic [IdxW:0]  lstart [MaxNest];
  logic [13:0]    lrem   [MaxNest];
  logic           lpush, ldec;
  logic [3:0]     sch, sch_next;
  logic           sphase, sphase_next;
  logic [31:0]    steps, steps_next, freq, freq_next, fok, fok_next;
  logic           abort_q, grant_q;

  logic           rv_next;
  out_item_t      res_next;

  // program store
  logic [StepW-1:0] rd;
  logic [IdxW-1:0]  raddr;
  lcs_ram #(.Width(StepW), .Depth(MaxSteps)) u_prog (
    .clk(clk),
    .we(!busy && start && in_item.mode == ModeLoad),
    .waddr(in_item.step_index[IdxW-1:0]),
    .wdata({in_item.step_op, in_item.arg_a, in_item.arg_b, in_item.arg_c}),
    .raddr(raddr),
    .rdata(rd)
  );
  assign raddr = pc[IdxW-1:0];

  logic [3:0]  r_op;
  logic [19:0] r_a;
  logic [16:0] r_b;
  logic [15:0] r_c;
  assign {r_op, r_a, r_b, r_c} = rd;

  logic [3:0] last_ch;
  assign last_ch = (r_b > 17'd15) ? 4'd15 : r_b[3:0];

  logic [NestW-1:0] top;
  assign top = NestW'(depth - 1'b1);

  assign busy = (state != ST_IDLE);

  always_comb begin
    state_next = state; pc_next = pc; budget_next = budget; depth_next = depth;
    sch_next = sch; sphase_next = sphase; steps_next = steps;
    freq_next = freq; fok_next = fok;
    lpush = 1'b0; ldec = 1'b0;
    rv_next = 1'b0;
    res_next = '0;
    res_next.executed_count = steps;
    res_next.frames_asked   = freq;
    res_next.frames_allowed = fok;
    case (state)
      ST_IDLE: ;
      ST_GRANT: begin
        // pending transmit answered by this item's grant bit
        if (!grant_q) begin
          rv_next = 1'b1; res_next.cmd_kind = KDone; res_next.run_status = SDenied;
          res_next.failed_at = pc[5:0];
          state_next = ST_IDLE;
        end else begin
          fok_next = fok + 32'(r_b); pc_next = pc + 1'b1; state_next = ST_FETCH;
        end
      end
      ST_FETCH: begin
        // RAM read issued on pc; check terminations first
        if (pc >= plen || budget == '0) begin
          rv_next = 1'b1; res_next.cmd_kind = KDone; res_next.run_status = SOk;
          state_next = ST_IDLE;
        end else begin
          budget_next = budget - 1'b1;
          if (abort_q) begin
            rv_next = 1'b1; res_next.cmd_kind = KDone; res_next.run_status = SAbort;
            res_next.failed_at = pc[5:0];
            state_next = ST_IDLE;
          end else begin
            steps_next = steps + 1'b1;
            state_next = ST_EXEC;
          end
        end
      end
      ST_EXEC: begin
        res_next.executed_count = steps;
        state_next = ST_IDLE;
        case (r_op)
          OP_LOG: begin
            rv_next = 1'b1; res_next.cmd_kind = KLog;
            res_next.cmd_value = 20'(pc); pc_next = pc + 1'b1;
          end
          OP_CHAN: begin
            rv_next = 1'b1; res_next.cmd_kind = KChan; res_next.cmd_value = r_a;
            pc_next = pc + 1'b1;
          end
          OP_SCAN: begin
            rv_next = 1'b1; res_next.cmd_kind = KScan; res_next.cmd_value = r_a;
            pc_next = pc + 1'b1;
          end
          OP_WAIT: begin
            rv_next = 1'b1; res_next.cmd_kind = KWait; res_next.cmd_value = r_a;
            pc_next = pc + 1'b1;
          end
          OP_SWEEP: begin
            if (r_a > 20'(last_ch)) begin
              pc_next = pc + 1'b1; state_next = ST_FETCH;
            end else begin
              rv_next = 1'b1; res_next.cmd_kind = KChan; res_next.cmd_value = r_a;
              sch_next = r_a[3:0]; sphase_next = 1'b1;
            end
          end
          OP_TX: begin
            freq_next = freq + 32'(r_b);
            rv_next = 1'b1; res_next.cmd_kind = KTx; res_next.cmd_value = 20'(r_b);
            res_next.tx_setting = r_a[3:0];
            res_next.frames_asked = freq + 32'(r_b);
          end
          OP_REPEAT: begin
            if (depth >= (NestW+1)'(MaxNest)) begin
              rv_next = 1'b1; res_next.cmd_kind = KDone; res_next.run_status = SNest;
              res_next.failed_at = pc[5:0];
            end else begin
              lpush = 1'b1; depth_next = depth + 1'b1;
              pc_next = pc + 1'b1; state_next = ST_FETCH;
            end
          end
          OP_END: begin
            if (depth == '0) begin
              rv_next = 1'b1; res_next.cmd_kind = KDone; res_next.run_status = SUnbal;
              res_next.failed_at = pc[5:0];
            end else if (lrem[top] > 14'd1) begin
              ldec = 1'b1; pc_next = lstart[top]; state_next = ST_FETCH;
            end else begin
              depth_next = depth - 1'b1;
              pc_next = pc + 1'b1; state_next = ST_FETCH;
            end
          end
          default: begin
            rv_next = 1'b1; res_next.cmd_kind = KDone; res_next.run_status = SOpcode;
            res_next.failed_at = pc[5:0];
          end
        endcase
      end
      ST_SWEEP: begin
        // RAM holds the sweep step at pc
        rv_next = 1'b1; state_next = ST_IDLE;
        if (!sphase) begin
          res_next.cmd_kind = KChan; res_next.cmd_value = 20'(sch);
          sphase_next = 1'b1;
        end else begin
          res_next.cmd_kind = KScan; res_next.cmd_value = 20'(r_c);
          sphase_next = 1'b0;
          if (sch >= last_ch) pc_next = pc + 1'b1;
          else sch_next = sch + 1'b1;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // run-level flags kept beside the FSM
  logic running, sweeping, awaiting;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE; pc <= '0; plen <= '0; budget <= '0; depth <= '0;
      sch <= '0; sphase <= 1'b0; steps <= '0; freq <= '0; fok <= '0;
      running <= 1'b0; sweeping <= 1'b0; awaiting <= 1'b0;
      result_valid <= 1'b0; abort_q <= 1'b0; grant_q <= 1'b0;
    end else begin
      result_valid <= rv_next;
      if (state != ST_IDLE) begin
        state <= state_next; pc <= pc_next; budget <= budget_next;
        depth <= depth_next; sch <= sch_next; sphase <= sphase_next;
        steps <= steps_next; freq <= freq_next; fok <= fok_next;
        if (state == ST_EXEC && r_op == OP_TX) awaiting <= 1'b1;
        if (state == ST_EXEC && r_op == OP_SWEEP && rv_next) sweeping <= 1'b1;
        if (state == ST_SWEEP && sphase && sch >= last_ch) sweeping <= 1'b0;
        if (rv_next && res_next.cmd_kind == KDone) running <= 1'b0;
      end else if (start) begin
        abort_q <= in_item.abort_now;
        grant_q <= in_item.tx_granted;
        if (in_item.mode == ModeStart) begin
          plen <= (in_item.step_total > 7'(MaxSteps)) ? (IdxW+1)'(MaxSteps)
                                                     : (IdxW+1)'(in_item.step_total);
          budget <= (in_item.run_budget == '0) ? DefaultBudget : in_item.run_budget;
          pc <= '0; depth <= '0; sch <= '0; sphase <= 1'b0;
          steps <= '0; freq <= '0; fok <= '0;
          running <= 1'b1; sweeping <= 1'b0; awaiting <= 1'b0;
        end else if (in_item.mode == ModeNext && running) begin
          if (awaiting) begin
            awaiting <= 1'b0; state <= ST_GRANT;
          end else if (sweeping) state <= ST_SWEEP;
          else state <= ST_FETCH;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    result <= res_next;
  end

  // loop stack
  always_ff @(posedge clk) begin
    if (state == ST_EXEC) begin
      if (lpush) begin
        lstart[depth[NestW-1:0]] <= pc + 1'b1;
        lrem[depth[NestW-1:0]]   <= (r_a > 20'(RepeatMax)) ? RepeatMax : r_a[13:0];
      end
      if (ldec) lrem[top] <= lrem[top] - 1'b1;
    end
  end
endmodule

/* hw/rtl/lcs_ram.sv */
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
module lcs_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

/* hw/rtl/lcs_checker.sv */
// Port-level checks for the looping command sequencer.
// Depends on lcs_pkg; bound to looping_command_sequencer_unit.
module lcs_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input lcs_pkg::in_item_t  in_item,
  input logic               result_valid,
  input lcs_pkg::out_item_t result
);
  import lcs_pkg::*;

  // no result while idle except right after leaving work
  a_res_after_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy)) else $error("result without work");

  // load items never produce results
  a_load_quiet: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && in_item.mode == ModeLoad) |=> !result_valid)
    else $error("load gave result");

  // status only on run finished
  a_status: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.cmd_kind != KDone) |-> result.run_status == SOk)
    else $error("status on command");

  // a result ends the work of the item
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !busy) else $error("busy after result");
endmodule

bind looping_command_sequencer_unit lcs_checker u_lcs_checker (.*);
